// ----- rtl/mht_pkg.sv -----
// Package for the multichannel hysteresis thermostat.
// Holds the controller state type, register indexes and temperature constants.
// No dependencies.
package mht_pkg;

  localparam int SumWidth   = 24;
  localparam int CountWidth = 8;
  localparam int TempWidth  = 15;
  localparam int BandWidth  = 10;
  localparam int ChanWidth  = 3;
  localparam int RelayCount = 7;
  localparam int ThrWidth   = 17;
  localparam int StepWidth  = 5;

  localparam logic [StepWidth-1:0] DivLastStep = StepWidth'(SumWidth - 1);

  localparam logic signed [TempWidth-1:0] TempMin = -15'sd4000;
  localparam logic signed [TempWidth-1:0] TempMax = 15'sd12500;
  localparam logic [SumWidth-1:0] MagMin = 24'd4000;
  localparam logic [SumWidth-1:0] MagMax = 24'd12500;

  localparam logic [BandWidth-1:0] BandReset = 10'd50;

  localparam logic RegBand = 1'b0;
  localparam logic RegAuto = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_FIX,
    S_CMP,
    S_DONE
  } state_t;

endpackage

// ----- rtl/multichannel_hysteresis_thermostat.sv -----
// Multichannel hysteresis thermostat: averages a sensor report bit-serially and drives relays.
// Depends on mht_pkg for the state type and constants.
// One item is worked on at a time.
// The 24-step restoring divider retires one quotient bit per cycle.
// Reset (synchronous): all relays off, hysteresis band 50, auto mode off, no result pending.
module multichannel_hysteresis_thermostat (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [mht_pkg::BandWidth-1:0]        cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [mht_pkg::ChanWidth-1:0]        sensor_channel,
  input  logic signed [mht_pkg::SumWidth-1:0]  sample_sum,
  input  logic [mht_pkg::CountWidth-1:0]       sample_count,
  input  logic signed [mht_pkg::TempWidth-1:0] target_temp,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           relay_bits,
  output logic signed [mht_pkg::TempWidth-1:0] average_temp
);

  mht_pkg::state_t state, state_next;

  logic [mht_pkg::BandWidth-1:0]        band;
  logic                                 auto_mode;
  logic [mht_pkg::RelayCount-1:0]       relay_state;
  logic [mht_pkg::ChanWidth-1:0]        chan;
  logic [mht_pkg::CountWidth-1:0]       divisor;
  logic signed [mht_pkg::TempWidth-1:0] target;
  logic                                 sum_neg;
  logic [mht_pkg::SumWidth-1:0]         dvd;
  logic [mht_pkg::CountWidth-1:0]       rem;
  logic [mht_pkg::StepWidth-1:0]        step;
  logic signed [mht_pkg::TempWidth-1:0] avg;
  logic signed [mht_pkg::ThrWidth-1:0]  thr_lo;
  logic signed [mht_pkg::ThrWidth-1:0]  thr_hi;

  logic                                 in_xfer;
  logic                                 out_load;
  logic [mht_pkg::CountWidth+1:0]       trial;
  logic [mht_pkg::SumWidth-1:0]         sum_mag;
  logic signed [mht_pkg::ThrWidth-1:0]  avg_wide;
  logic signed [mht_pkg::ThrWidth-1:0]  target_wide;
  logic signed [mht_pkg::ThrWidth-1:0]  band_wide;

  assign in_xfer  = in_valid && in_ready;
  assign out_load = (state == mht_pkg::S_DONE) && (!out_valid || out_ready);
  assign trial    = {1'b0, rem, dvd[mht_pkg::SumWidth-1]} - {2'b00, divisor};
  assign sum_mag  = sample_sum[mht_pkg::SumWidth-1] ? mht_pkg::SumWidth'(-sample_sum)
                                                     : mht_pkg::SumWidth'(sample_sum);
  assign avg_wide    = mht_pkg::ThrWidth'(avg);
  assign target_wide = mht_pkg::ThrWidth'(target);
  assign band_wide   = mht_pkg::ThrWidth'({1'b0, band});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mht_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      mht_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = mht_pkg::S_DIV;
        end
      end
      mht_pkg::S_DIV: begin
        if (step == mht_pkg::DivLastStep) begin
          state_next = mht_pkg::S_FIX;
        end
      end
      mht_pkg::S_FIX: state_next = mht_pkg::S_CMP;
      mht_pkg::S_CMP: state_next = mht_pkg::S_DONE;
      mht_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = mht_pkg::S_IDLE;
        end
      end
      default: state_next = mht_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      band      <= mht_pkg::BandReset;
      auto_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mht_pkg::RegBand: band      <= cfg_data;
        mht_pkg::RegAuto: auto_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      chan    <= sensor_channel;
      divisor <= sample_count;
      target  <= target_temp;
      sum_neg <= sample_sum[mht_pkg::SumWidth-1];
      dvd     <= sum_mag;
      rem     <= '0;
      step    <= '0;
    end else if (state == mht_pkg::S_DIV) begin
      step <= step + 1'b1;
      if (trial[mht_pkg::CountWidth+1]) begin
        rem <= {rem[mht_pkg::CountWidth-2:0], dvd[mht_pkg::SumWidth-1]};
        dvd <= {dvd[mht_pkg::SumWidth-2:0], 1'b0};
      end else begin
        rem <= trial[mht_pkg::CountWidth-1:0];
        dvd <= {dvd[mht_pkg::SumWidth-2:0], 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == mht_pkg::S_FIX) begin
      thr_lo <= target_wide - band_wide;
      thr_hi <= target_wide + band_wide;
      priority if (divisor == '0) begin
        avg <= '0;
      end else if (sum_neg) begin
        avg <= (dvd > mht_pkg::MagMin) ? mht_pkg::TempMin
                                       : mht_pkg::TempWidth'(-dvd[mht_pkg::TempWidth-1:0]);
      end else begin
        avg <= (dvd > mht_pkg::MagMax) ? mht_pkg::TempMax
                                       : mht_pkg::TempWidth'(dvd[mht_pkg::TempWidth-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      relay_state <= '0;
    end else if (state == mht_pkg::S_CMP && divisor != '0 && chan != '0) begin
      priority if (avg_wide < thr_lo) begin
        relay_state[chan - 1'b1] <= 1'b1;
      end else if (avg_wide > thr_hi) begin
        relay_state[chan - 1'b1] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      relay_bits   <= {auto_mode, relay_state};
      average_temp <= avg;
    end
  end

  a_accept_starts_divide: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == mht_pkg::S_DIV) && (step == '0))
    else $error("Accepted report did not start the divider.");

  a_divide_length: assert property (@(posedge clk) disable iff (rst)
    (state == mht_pkg::S_DIV) && (step == mht_pkg::DivLastStep) |=> state == mht_pkg::S_FIX)
    else $error("Divider did not finish after its last step.");

  a_remainder_bound: assert property (@(posedge clk) disable iff (rst)
    (state == mht_pkg::S_DIV) && (divisor != '0) |-> rem < divisor)
    else $error("Divider remainder reached the divisor.");

  a_relays_change_in_compare: assert property (@(posedge clk) disable iff (rst)
    (state != mht_pkg::S_CMP) |=> $stable(relay_state))
    else $error("Relay state changed outside the compare step.");

  a_result_after_done: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && (state == mht_pkg::S_IDLE))
    else $error("Result load did not raise the output valid.");

endmodule

// ----- verif/mht_checker.sv -----
// Checker for the multichannel hysteresis thermostat: predicts each relay byte and average.
// Watches the configuration port and both handshakes; depends on mht_pkg for widths and indexes.
`timescale 1ns / 1ps

module mht_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [mht_pkg::BandWidth-1:0]        cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [mht_pkg::ChanWidth-1:0]        sensor_channel,
  input  logic signed [mht_pkg::SumWidth-1:0]  sample_sum,
  input  logic [mht_pkg::CountWidth-1:0]       sample_count,
  input  logic signed [mht_pkg::TempWidth-1:0] target_temp,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic [7:0]                           relay_bits,
  input  logic signed [mht_pkg::TempWidth-1:0] average_temp,
  output int                                   failures,
  output int                                   readings_due
);

  typedef struct packed {
    logic [7:0]                           relays;
    logic signed [mht_pkg::TempWidth-1:0] avg;
  } reading_t;

  reading_t                       reading_q[$];
  logic [mht_pkg::RelayCount-1:0] relay_copy;
  logic [mht_pkg::BandWidth-1:0]  band_copy;
  logic                           auto_copy;
  int                             fail_total = 0;

  assign failures = fail_total;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
    fail_total++;
  endtask

  function automatic reading_t thermostat_step(
      input logic [mht_pkg::ChanWidth-1:0] chan,
      input logic signed [mht_pkg::SumWidth-1:0] sum,
      input logic [mht_pkg::CountWidth-1:0] count,
      input logic signed [mht_pkg::TempWidth-1:0] setpoint);
    reading_t r;
    int       mean;
    int       low_edge;
    int       high_edge;
    mean = 0;
    if (count != 0) begin
      mean = int'(sum) / int'(count);
      if (mean < int'(mht_pkg::TempMin)) mean = int'(mht_pkg::TempMin);
      if (mean > int'(mht_pkg::TempMax)) mean = int'(mht_pkg::TempMax);
      if (chan != 0) begin
        low_edge  = int'(setpoint) - int'(band_copy);
        high_edge = int'(setpoint) + int'(band_copy);
        if (mean < low_edge) relay_copy[chan - 1] = 1'b1;
        if (mean > high_edge) relay_copy[chan - 1] = 1'b0;
      end
    end
    r.relays = {auto_copy, relay_copy};
    r.avg    = mht_pkg::TempWidth'(mean);
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      relay_copy = '0;
      band_copy  = mht_pkg::BandReset;
      auto_copy  = 1'b0;
      reading_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mht_pkg::RegBand: band_copy = cfg_data;
          mht_pkg::RegAuto: auto_copy = cfg_data[0];
        endcase
      end
      if (in_valid && in_ready) begin
        reading_q.push_back(thermostat_step(sensor_channel, sample_sum, sample_count,
                                            target_temp));
      end
      if (out_valid && out_ready) begin
        if (reading_q.size() == 0) begin
          report("unexpected result", {24'd0, relay_bits}, 32'd0);
        end else begin
          want = reading_q.pop_front();
          if (relay_bits !== want.relays) begin
            report("relay_bits", {24'd0, relay_bits}, {24'd0, want.relays});
          end
          if (average_temp !== want.avg) begin
            report("average_temp", {17'd0, average_temp}, {17'd0, want.avg});
          end
        end
      end
    end
    readings_due <= reading_q.size();
  end

endmodule

// ----- verif/testbench.sv -----
// Top of the thermostat testbench: clock, reset, sensor reports, register writes and verdict.
// Depends on mht_pkg, the thermostat RTL and mht_checker, which does all prediction.
`timescale 1ns / 1ps

module testbench;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 cfg_we = 1'b0;
  logic                                 cfg_index = mht_pkg::RegBand;
  logic [mht_pkg::BandWidth-1:0]        cfg_data = '0;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic [mht_pkg::ChanWidth-1:0]        sensor_channel = '0;
  logic signed [mht_pkg::SumWidth-1:0]  sample_sum = '0;
  logic [mht_pkg::CountWidth-1:0]       sample_count = '0;
  logic signed [mht_pkg::TempWidth-1:0] target_temp = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic [7:0]                           relay_bits;
  logic signed [mht_pkg::TempWidth-1:0] average_temp;
  int                                   failures;
  int                                   readings_due;

  int                                   burst_left = 0;
  int                                   band_now = 50;
  int                                   stall_mode = 0;
  int                                   stall_left = 0;

  multichannel_hysteresis_thermostat dut (.*);

  mht_checker scoreboard (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("[multichannel_hysteresis_thermostat] ERROR");
    $finish;
  end

  // The receiver switches between free running, random, sparse and fully stalled stretches.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = (stall_mode == 3) ? $urandom_range(5, 60) : $urandom_range(20, 300);
    end
    stall_left--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= 1'b0;
    endcase
  end

  task automatic send_report(input int chan, input int sum, input int count, input int setpoint);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid       <= 1'b1;
    sensor_channel <= mht_pkg::ChanWidth'(chan);
    sample_sum     <= mht_pkg::SumWidth'(sum);
    sample_count   <= mht_pkg::CountWidth'(count);
    target_temp    <= mht_pkg::TempWidth'(setpoint);
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    if (burst_left > 0) begin
      in_valid   <= 1'b0;
      burst_left = 0;
    end
    @(posedge clk);
    while (readings_due != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= mht_pkg::BandWidth'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == mht_pkg::RegBand) band_now = value;
  endtask

  // Most reports put the average close to the dead band edges so the relays keep switching.
  task automatic random_report();
    int chan;
    int count;
    int setpoint;
    int mean;
    int sum;
    int pick;
    chan = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7);
    pick = $urandom_range(0, 19);
    if (pick < 2) count = 0;
    else if (pick < 4) count = $urandom_range(1, 255);
    else if (pick == 4) count = 255;
    else count = $urandom_range(1, 8);
    if ($urandom_range(0, 9) == 0) setpoint = $signed(mht_pkg::TempWidth'($urandom));
    else setpoint = $urandom_range(0, 16500) - 4000;
    if (count == 0 || $urandom_range(0, 9) == 0) begin
      sum = $signed(mht_pkg::SumWidth'($urandom));
    end else begin
      mean = setpoint + $urandom_range(0, 4 * band_now + 8) - (2 * band_now + 4);
      sum  = mean * count + $urandom_range(0, count - 1) * ($urandom_range(0, 1) ? 1 : -1);
    end
    send_report(chan, sum, count, setpoint);
  endtask

  initial begin
    int band_set[6];
    int auto_set[6];
    band_set = '{0, 1023, 50, 1000, 0, 0};
    auto_set = '{1, 0, 1, 0, 0, 0};
    band_set[4] = $urandom_range(0, 1023);
    band_set[5] = $urandom_range(0, 200);
    auto_set[4] = $urandom_range(0, 1);
    auto_set[5] = $urandom_range(0, 1);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_report(1, 2000, 1, 2100);
    send_report(1, 2080, 1, 2100);
    send_report(1, 2200, 1, 2100);
    send_report(1, 2050, 1, 2100);
    send_report(1, 2049, 1, 2100);
    send_report(1, 2150, 1, 2100);
    send_report(1, 2151, 1, 2100);
    send_report(0, 9999, 3, 5000);
    send_report(3, 12345, 0, 16383);
    send_report(7, 8388607, 1, 12500);
    send_report(2, -8388608, 1, 16383);
    send_report(4, -8388608, 255, -16384);
    send_report(5, -7, 2, 100);
    send_report(5, 7, 2, -100);
    send_report(6, 8388607, 255, 0);
    for (int ch = 1; ch <= 7; ch++) send_report(ch, 7006, 7, 5000);
    wait_idle();

    write_reg(mht_pkg::RegBand, 0);
    write_reg(mht_pkg::RegAuto, 1);
    send_report(3, 500, 1, 500);
    send_report(3, 499, 1, 500);
    send_report(3, 501, 1, 500);

    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      write_reg(mht_pkg::RegBand, band_set[phase]);
      write_reg(mht_pkg::RegAuto, auto_set[phase]);
      repeat (275) random_report();
    end
    wait_idle();

    if (failures == 0 && readings_due == 0) begin
      $display("[multichannel_hysteresis_thermostat] OK");
    end else begin
      $display("[multichannel_hysteresis_thermostat] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mht_pkg.sv
rtl/multichannel_hysteresis_thermostat.sv
verif/mht_checker.sv
verif/testbench.sv
